// File: rtl/core/range_rule_match_random_select_unit_defines.svh
// Assertion macros shared by the rule match unit.
`ifndef RANGE_RULE_MATCH_RANDOM_SELECT_UNIT_DEFINES_SVH
`define RANGE_RULE_MATCH_RANDOM_SELECT_UNIT_DEFINES_SVH

// Check that a condition implies another on the same edge.
`define RRM_ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Check that a condition implies another on the next edge.
`define RRM_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: rtl/core/rrm_pkg.sv
// ----------------------------------------------------------------------------
// rrm_pkg
// Types and constants shared by the rule match controller and datapath.
// ----------------------------------------------------------------------------
package rrm_pkg;

    localparam int BOUND_W   = 17;
    localparam int RAND_W    = 32;
    localparam int NUM_READS = 6;

    // Word codes inside one entry
    localparam logic [3:0] WORD_URGENT  = 4'd0;
    localparam logic [3:0] WORD_ACTION  = 4'd1;
    localparam logic [3:0] WORD_NEEDPM  = 4'd2;
    localparam logic [3:0] WORD_BOUND0  = 4'd3;
    localparam logic [3:0] WORD_UNUSED  = 4'd15;

    // Configuration register indexes
    localparam logic CFG_ENTRIES = 1'b0;
    localparam logic CFG_PM      = 1'b1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MARK,
        ST_DIVIDE,
        ST_SELECT,
        ST_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;      // capture query
        logic mark;      // one step of the entry check
        logic div_step;  // one remainder step
        logic sel;       // scan one mark
        logic clear;     // reset scan index, take the remainder
        logic finish;    // emit result
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic mark_last;
        logic div_last;
        logic sel_hit;
        logic sel_last;
        logic none;
    } t_status;

endpackage

// File: rtl/core/rrm_datapath.sv
// ----------------------------------------------------------------------------
// rrm_datapath
// Entry tables, per-entry range check, serial remainder and mark scan.
// ----------------------------------------------------------------------------
module rrm_datapath import rrm_pkg::*; #(
    parameter int MAX_ENTRIES = 64,
    parameter int IDX_W       = 6,
    parameter int CNT_W       = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    input  logic                i_wr_en,
    input  logic [9:0]          i_table_address,
    input  logic [16:0]         i_write_value,
    input  logic [CNT_W-1:0]    i_used,
    input  logic                i_pm_present,
    input  logic [4:0]          i_query_flags,
    input  logic [3:0]          i_request_action,
    input  logic [15:0]         i_co2_reading,
    input  logic [11:0]         i_temp_reading,
    input  logic [9:0]          i_humidity_reading,
    input  logic [9:0]          i_voc_reading,
    input  logic [9:0]          i_nox_reading,
    input  logic [11:0]         i_pm_reading,
    input  logic [RAND_W-1:0]   i_random_value,
    output logic                o_found,
    output logic [5:0]          o_chosen_entry,
    output logic [6:0]          o_match_count
);

    localparam int BW_DEPTH = MAX_ENTRIES * 12;
    localparam int BA_W     = $clog2(BW_DEPTH);

    logic [1:0]          r_flags  [MAX_ENTRIES];
    logic [3:0]          r_action [MAX_ENTRIES];
    logic [BOUND_W-1:0]  r_bounds [BW_DEPTH];
    logic [MAX_ENTRIES-1:0] r_marks;

    logic [4:0]          r_qf;
    logic [3:0]          r_act;
    logic signed [BOUND_W-1:0] r_rd [NUM_READS];
    logic [RAND_W-1:0]   r_rand;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W:0]      r_idx;      // entry scan index
    logic [3:0]          r_word;     // bound word 0..11 within entry, 12 when all read
    logic                r_ok;       // running match of current entry
    logic [CNT_W-1:0]    r_rem;
    logic [5:0]          r_bit;
    logic [CNT_W-1:0]    r_pick;
    logic [5:0]          r_chosen;
    logic                r_found;
    logic [CNT_W-1:0]    r_out_cnt;
    logic signed [BOUND_W-1:0] r_bnd;  // registered bound read
    logic [1:0]          r_hflags;   // registered flags of entry under check
    logic [3:0]          r_hact;     // registered action of entry under check

    // One bound read in flight: word w is read, checked the next cycle
    logic [3:0]          r_word_prev;
    logic                r_chk;

    logic [IDX_W-1:0]    idx;
    logic [5:0]          wr_entry;
    logic [3:0]          wr_word;
    logic [BA_W-1:0]     wr_addr;
    logic [BA_W-1:0]     rd_addr;
    logic [2:0]          rsel;
    logic                avail;
    logic signed [BOUND_W-1:0] rval;
    logic                bnd_fail;
    logic                head_ok;
    logic                in_use;
    logic [CNT_W:0]      rem_sh;
    logic [CNT_W-1:0]    rem_nx;

    assign idx      = r_idx[IDX_W-1:0];
    assign wr_entry = i_table_address[9:4];
    assign wr_word  = i_table_address[3:0];
    assign wr_addr  = BA_W'(32'(wr_entry) * 12 + 32'(wr_word - WORD_BOUND0));
    assign rd_addr  = BA_W'(32'(idx) * 12 + 32'(r_word));

    // Store table words and register the reads of the entry under check
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (32'(wr_entry) < MAX_ENTRIES)) begin
            case (wr_word)
                WORD_URGENT: r_flags[wr_entry[IDX_W-1:0]][0] <= i_write_value[0];
                WORD_ACTION: r_action[wr_entry[IDX_W-1:0]]   <= i_write_value[3:0];
                WORD_NEEDPM: r_flags[wr_entry[IDX_W-1:0]][1] <= i_write_value[0];
                WORD_UNUSED: ;
                default:     r_bounds[wr_addr] <= i_write_value;
            endcase
        end
        r_bnd    <= r_bounds[rd_addr];
        r_hflags <= r_flags[idx];
        r_hact   <= r_action[idx];
    end

    // Select the reading and its availability for the bound just read
    always_comb begin
        rsel = r_word_prev[3:1];
        rval = r_rd[rsel];
        case (rsel)
            3'd3:    avail = r_qf[1] & r_qf[2];
            3'd4:    avail = r_qf[1] & r_qf[3];
            3'd5:    avail = r_qf[1] & i_pm_present & r_qf[4];
            default: avail = r_qf[1];
        endcase
        if (r_bnd == '0) begin
            bnd_fail = 1'b0;
        end else if (r_word_prev[0] == 1'b0) begin
            bnd_fail = !avail || (rval < r_bnd);
        end else begin
            bnd_fail = !avail || (rval > r_bnd);
        end
        in_use  = r_idx < (CNT_W+1)'(i_used);
        head_ok = in_use && (r_hflags[0] == r_qf[0])
            && (r_hact == 4'd0 || r_hact == r_act)
            && !(r_hflags[1] && !i_pm_present);
        rem_sh  = {r_rem, r_rand[RAND_W-1 - 32'(r_bit[4:0])]};
        if (rem_sh >= {1'b0, r_count}) begin
            rem_nx = CNT_W'(rem_sh - {1'b0, r_count});
        end else begin
            rem_nx = CNT_W'(rem_sh);
        end
    end

    // Query sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marks <= '0;
            r_found <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_qf   <= i_query_flags;
                r_act  <= i_request_action;
                r_rd[0] <= BOUND_W'(i_co2_reading);
                r_rd[1] <= BOUND_W'(signed'(i_temp_reading));
                r_rd[2] <= BOUND_W'(i_humidity_reading);
                r_rd[3] <= BOUND_W'(i_voc_reading);
                r_rd[4] <= BOUND_W'(i_nox_reading);
                r_rd[5] <= BOUND_W'(i_pm_reading);
                r_rand <= i_random_value;
                r_count <= '0;
                r_idx  <= '0;
                r_word <= '0;
                r_ok   <= 1'b1;
                r_chk  <= 1'b0;
                r_rem  <= '0;
                r_bit  <= '0;
            end
            if (i_cmd.mark) begin
                // Pipeline: r_word addresses the table, r_word_prev is checked
                r_word_prev <= r_word;
                r_chk       <= (r_word != 4'd12);
                if (r_chk && bnd_fail) begin
                    r_ok <= 1'b0;
                end
                if (r_word == 4'd12) begin
                    // all bounds of this entry checked once r_chk drains
                    if (!r_chk) begin
                        r_marks[idx] <= r_ok && head_ok;
                        if (r_ok && head_ok) begin
                            r_count <= r_count + 1'b1;
                        end
                        r_idx  <= r_idx + 1'b1;
                        r_word <= '0;
                        r_ok   <= 1'b1;
                    end
                end else begin
                    r_word <= r_word + 1'b1;
                end
            end
            if (i_cmd.div_step) begin
                r_rem <= rem_nx;
                r_bit <= r_bit + 1'b1;
            end
            // Take the final remainder when the last step runs in this cycle
            if (i_cmd.clear) begin
                r_idx  <= '0;
                r_pick <= i_cmd.div_step ? rem_nx : r_rem;
            end
            if (i_cmd.sel) begin
                if (r_marks[idx]) begin
                    r_pick <= r_pick - 1'b1;
                end
                if (!o_status.sel_hit) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_found   <= (r_count != '0);
                r_chosen  <= (r_count != '0) ? 6'(idx) : 6'd0;
                r_out_cnt <= r_count;
            end
        end
    end

    assign o_status.mark_last = (r_word == 4'd12) && !r_chk
        && (r_idx == (CNT_W+1)'(MAX_ENTRIES - 1));
    assign o_status.div_last  = (r_bit == 6'(RAND_W - 1));
    assign o_status.sel_hit   = r_marks[idx] && (r_pick == '0);
    assign o_status.sel_last  = (r_idx == (CNT_W+1)'(MAX_ENTRIES - 1));
    assign o_status.none      = (r_count == '0);

    assign o_found        = r_found;
    assign o_chosen_entry = r_found ? r_chosen : 6'd0;
    assign o_match_count  = r_found ? 7'(r_out_cnt) : 7'd0;

endmodule

// File: rtl/core/rrm_ctrl.sv
// ----------------------------------------------------------------------------
// rrm_ctrl
// Sequencer for one query: mark, remainder, select, report.
// ----------------------------------------------------------------------------
module rrm_ctrl import rrm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_query,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy,
    output logic    o_done
);

    t_state r_state, n_state;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance through the query phases
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_done  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_query) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MARK;
                end
            end
            ST_LOAD: begin
                n_state = ST_MARK;
            end
            ST_MARK: begin
                o_cmd.mark = 1'b1;
                if (i_status.mark_last) begin
                    n_state = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                // No match: report an empty result right away
                if (i_status.none) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_DONE;
                end else begin
                    o_cmd.div_step = 1'b1;
                    if (i_status.div_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = ST_SELECT;
                    end
                end
            end
            ST_SELECT: begin
                o_cmd.sel = 1'b1;
                if (i_status.sel_hit || i_status.sel_last) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.sel    = 1'b0;
                    n_state      = ST_DONE;
                end
            end
            ST_DONE: begin
                o_done  = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// File: rtl/core/range_rule_match_random_select_unit.sv
// ----------------------------------------------------------------------------
// range_rule_match_random_select_unit
// Rule table with range matching and random choice among matching entries.
// ----------------------------------------------------------------------------
// Use: raise start with the item fields; the item goes in at an edge where
// busy is low. A write item (operation 0) stores one table word at that edge
// and gives no result; writes can follow back to back while idle.
// A query item (operation 1) checks every entry, one bound word per cycle
// through the bound memory read port, then takes the random word modulo
// the count one bit per cycle (skipped when nothing matched), then scans
// the marks one entry per cycle up to the chosen one. The result shows on
// o_found, o_chosen_entry, o_match_count with o_valid high for one cycle;
// busy drops the cycle after. The receiver cannot stall; the result values
// stay on the outputs until the next query finishes. Configuration writes
// (i_cfg_valid/o_cfg_ready) go in whenever the unit is idle; register 0 is
// the entry count in use, register 1 the particulate sensor present flag.
// Reset clears control state and configuration; table contents stay
// undefined until written.
// ----------------------------------------------------------------------------
`include "range_rule_match_random_select_unit_defines.svh"
module range_rule_match_random_select_unit import rrm_pkg::*; #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_operation,
    input  logic [9:0]  i_table_address,
    input  logic [16:0] i_write_value,
    input  logic [4:0]  i_query_flags,
    input  logic [3:0]  i_request_action,
    input  logic [15:0] i_co2_reading,
    input  logic [11:0] i_temp_reading,
    input  logic [9:0]  i_humidity_reading,
    input  logic [9:0]  i_voc_reading,
    input  logic [9:0]  i_nox_reading,
    input  logic [11:0] i_pm_reading,
    input  logic [31:0] i_random_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    output logic        o_valid,
    output logic        o_found,
    output logic [5:0]  o_chosen_entry,
    output logic [6:0]  o_match_count
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    logic [6:0]       r_used;
    logic             r_pm;
    logic [CNT_W-1:0] used_sat;
    t_cmd             cmd;
    t_status          status;
    logic             accept;
    logic             done;

    assign accept      = start && !busy;
    assign o_cfg_ready = !busy;
    assign used_sat    = (32'(r_used) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES)
                                                     : CNT_W'(r_used);

    // Hold configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_pm   <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ENTRIES: r_used <= i_cfg_data;
                CFG_PM:      r_pm   <= i_cfg_data[0];
                default:     ;
            endcase
        end
    end

    rrm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_query  (accept && (i_operation == OP_QUERY)),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_done   (done)
    );

    rrm_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_wr_en            (accept && (i_operation == OP_WRITE)),
        .i_table_address    (i_table_address),
        .i_write_value      (i_write_value),
        .i_used             (used_sat),
        .i_pm_present       (r_pm),
        .i_query_flags      (i_query_flags),
        .i_request_action   (i_request_action),
        .i_co2_reading      (i_co2_reading),
        .i_temp_reading     (i_temp_reading),
        .i_humidity_reading (i_humidity_reading),
        .i_voc_reading      (i_voc_reading),
        .i_nox_reading      (i_nox_reading),
        .i_pm_reading       (i_pm_reading),
        .i_random_value     (i_random_value),
        .o_found            (o_found),
        .o_chosen_entry     (o_chosen_entry),
        .o_match_count      (o_match_count)
    );

    assign o_valid = done;

    // Checks
    `RRM_ASSERT_IMPLY(a_no_start_busy, i_clk, i_rst_n, o_valid, busy, "result while idle")
    `RRM_ASSERT_NEXT(a_idle_after, i_clk, i_rst_n, o_valid, !busy, "busy after result")
    `RRM_ASSERT_IMPLY(a_found_cnt, i_clk, i_rst_n, o_valid && o_found,
        o_match_count != 7'd0, "found with zero count")

endmodule
